// ===== hw/rtl/mep_pkg.sv =====
// ============================================================================
// mep_pkg - shared types and constants of the escape-time pixel core
// Fixed-point format, register indexes, reset values and sequencer states.
// ============================================================================
package mep_pkg;

  // Signed fixed point: FRACTION_BITS fraction bits (Q4.28).
  localparam int FRACTION_BITS = 28;

  // Magnitude operand width of the squaring unit: |z| <= 2.0 when it is used.
  localparam int MAG_W = FRACTION_BITS + 2;
  // Width of one truncated product: at most 4.0.
  localparam int SQ_W  = FRACTION_BITS + 3;

  localparam int COORD_W = 32;
  localparam int LIMIT_W = 16;
  localparam int COLOR_W = 24;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 24'hFF_FFFF;

  // Quotient bits produced by the color divider.
  localparam int DIV_STEPS = COLOR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_ORIGIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 3'd4;

  // Reset values: origin -2.0, step about 0.004, limit 1000.
  localparam logic [COORD_W-1:0] ORIGIN_RST = 32'hE000_0000;
  localparam logic [COORD_W-1:0] STEP_RST   = 32'd1073742;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_MUL,
    ST_UPD,
    ST_DIV
  } mep_state_t;

endpackage

// ===== hw/rtl/mandelbrot_escape_pixel_core.sv =====
// ============================================================================
// mandelbrot_escape_pixel_core - escape-time iteration for one pixel
// Maps a pixel to a point c, iterates z = z^2 + c and returns the
// iteration count and a gray level scaled to the configured limit.
// ============================================================================
//
// Usage:
//   The input stream carries one pixel per transaction (column, row). The
//   output stream returns one transaction per pixel: the iteration count and
//   the gray level floor(0xFFFFFF * count / limit). Configuration writes go
//   through cfg_we / cfg_index / cfg_data; make them only while the core is
//   idle and no result is waiting.
//   Timing: the sequencer maps the pixel to c, then runs the iteration loop,
//   then the color divider. Each iteration passes through the three squaring
//   multipliers and then the add, compare and update adder. The loop ends on
//   the limit or far test before the multipliers, or on the |z|^2 test in the
//   adder. The restoring color divider then forms the 24 quotient bits one by
//   one and loads the output register. The sequencer returns to idle, ready
//   for the next pixel, in the same cycle that the result appears on the
//   output.
//   in_tready is high only while the sequencer is idle.
//   A finished result parks in the output register, so the next pixel is
//   accepted while the receiver stalls; a second result then waits in the
//   divider until the output register drains.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
//   pending result and loads the default view: origin -2.0 on both axes,
//   step 1073742 per pixel, limit 1000.
//
module mandelbrot_escape_pixel_core
  import mep_pkg::*;
#(
  parameter int PIXEL_INDEX_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Pixel input: {row, column}, column in the lowest bits.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [((2*PIXEL_INDEX_BITS+7)/8)*8-1:0] in_tdata,
  // Result output: {gray_color[23:0], iterations[15:0]}, iterations lowest.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [LIMIT_W+COLOR_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_W-1:0]         cfg_data
);

  localparam int PW   = PIXEL_INDEX_BITS;
  // Mapped coordinate: origin plus index times step.
  localparam int C_W  = COORD_W + PW + 2;
  // Iterate z: squares and 2xy add at most a few units to c.
  localparam int Z_W  = C_W + 1;
  localparam int PM_W = 2 * MAG_W;

  localparam logic [Z_W-1:0]  TWO_Q  = Z_W'(1) << (FRACTION_BITS + 1);
  localparam logic [SQ_W:0]   FOUR_Q = (SQ_W + 1)'(1) << (FRACTION_BITS + 2);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] x_origin_r, x_step_r, y_origin_r, y_step_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= ORIGIN_RST;
      x_step_r   <= STEP_RST;
      y_origin_r <= ORIGIN_RST;
      y_step_r   <= STEP_RST;
      limit_r    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin_r <= cfg_data;
        REG_X_STEP:   x_step_r   <= cfg_data;
        REG_Y_ORIGIN: y_origin_r <= cfg_data;
        REG_Y_STEP:   y_step_r   <= cfg_data;
        REG_LIMIT:    limit_r    <= cfg_data[LIMIT_W-1:0];
        default: ;    // ignore writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  mep_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [PW-1:0]        col_r, col_nxt, row_r, row_nxt;
  logic [C_W-1:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic [Z_W-1:0]       x_r, x_nxt, y_r, y_nxt;
  logic [LIMIT_W-1:0]   n_r, n_nxt;
  logic [SQ_W-1:0]      x2_r, x2_nxt, y2_r, y2_nxt, xy_r, xy_nxt;
  logic                 neg_r, neg_nxt;
  logic [LIMIT_W-1:0]   rem_r, rem_nxt;
  logic [COLOR_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [LIMIT_W-1:0]   out_iter_r, out_iter_nxt;
  logic [COLOR_W-1:0]   out_gray_r, out_gray_nxt;

  // Pixel to point mapping: one 32 by PW+1 signed product per axis.
  logic signed [PW:0]        col_s, row_s;
  logic signed [COORD_W+PW:0] px, py;
  logic [C_W-1:0]            cx_map, cy_map;

  assign col_s  = $signed({1'b0, col_r});
  assign row_s  = $signed({1'b0, row_r});
  assign px     = col_s * $signed(x_step_r);
  assign py     = row_s * $signed(y_step_r);
  assign cx_map = {{(C_W-COORD_W){x_origin_r[COORD_W-1]}}, x_origin_r}
                + {{(C_W-COORD_W-PW-1){px[COORD_W+PW]}}, px};
  assign cy_map = {{(C_W-COORD_W){y_origin_r[COORD_W-1]}}, y_origin_r}
                + {{(C_W-COORD_W-PW-1){py[COORD_W+PW]}}, py};

  // Squaring unit: magnitudes, far test and three truncated products.
  logic [Z_W-1:0]   ax, ay;
  logic             far;
  logic [MAG_W-1:0] ax_m, ay_m;
  logic [PM_W-1:0]  p_xx, p_yy, p_xy;

  assign ax   = x_r[Z_W-1] ? (~x_r + Z_W'(1)) : x_r;
  assign ay   = y_r[Z_W-1] ? (~y_r + Z_W'(1)) : y_r;
  assign far  = (ax > TWO_Q) || (ay > TWO_Q);
  assign ax_m = ax[MAG_W-1:0];
  assign ay_m = ay[MAG_W-1:0];
  assign p_xx = ax_m * ax_m;
  assign p_yy = ay_m * ay_m;
  assign p_xy = ax_m * ay_m;

  // Update adder: |z|^2 test and next z.
  logic [SQ_W:0]  sq_sum;
  logic [Z_W-1:0] two_xy, two_xy_s, x_upd, y_upd;

  assign sq_sum   = {1'b0, x2_r} + {1'b0, y2_r};
  assign two_xy   = {{(Z_W-SQ_W-1){1'b0}}, xy_r, 1'b0};
  assign two_xy_s = neg_r ? (~two_xy + Z_W'(1)) : two_xy;
  assign x_upd    = {{(Z_W-SQ_W){1'b0}}, x2_r} - {{(Z_W-SQ_W){1'b0}}, y2_r}
                  + {cx_r[C_W-1], cx_r};
  assign y_upd    = two_xy_s + {cy_r[C_W-1], cy_r};

  // Divider: dividend 0xFFFFFF * n = n * 2^24 - n; quotient fits 24 bits.
  logic [LIMIT_W+COLOR_W-1:0] dividend;
  logic [LIMIT_W:0]           trial, trial_sub;
  logic                       load_out;

  assign dividend  = {n_r, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, n_r};
  assign trial     = {rem_r, quo_r[COLOR_W-1]};
  assign trial_sub = trial - {1'b0, limit_r};

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    n_nxt        = n_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    xy_nxt       = xy_r;
    neg_nxt      = neg_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    div_cnt_nxt  = div_cnt_r;
    out_iter_nxt = out_iter_r;
    out_gray_nxt = out_gray_r;
    load_out     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          col_nxt   = in_tdata[PW-1:0];
          row_nxt   = in_tdata[2*PW-1:PW];
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cx_nxt    = cx_map;
        cy_nxt    = cy_map;
        x_nxt     = {cx_map[C_W-1], cx_map};
        y_nxt     = {cy_map[C_W-1], cy_map};
        n_nxt     = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if ((n_r >= limit_r) || far) begin
          // Stop: limit reached or a component beyond 2.0.
          rem_nxt     = dividend[LIMIT_W+COLOR_W-1:COLOR_W];
          quo_nxt     = dividend[COLOR_W-1:0];
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end else begin
          x2_nxt    = p_xx[FRACTION_BITS +: SQ_W];
          y2_nxt    = p_yy[FRACTION_BITS +: SQ_W];
          xy_nxt    = p_xy[FRACTION_BITS +: SQ_W];
          neg_nxt   = x_r[Z_W-1] ^ y_r[Z_W-1];
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (sq_sum > FOUR_Q) begin
          rem_nxt     = dividend[LIMIT_W+COLOR_W-1:COLOR_W];
          quo_nxt     = dividend[COLOR_W-1:0];
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end else begin
          x_nxt     = x_upd;
          y_nxt     = y_upd;
          n_nxt     = n_r + LIMIT_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_cnt_r != DIV_CNT_W'(DIV_STEPS)) begin
          // Restoring step: shift in one dividend bit, keep the difference
          // when it does not go negative.
          if (!trial_sub[LIMIT_W]) begin
            rem_nxt = trial_sub[LIMIT_W-1:0];
          end else begin
            rem_nxt = trial[LIMIT_W-1:0];
          end
          quo_nxt     = {quo_r[COLOR_W-2:0], ~trial_sub[LIMIT_W]};
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end else if (!out_valid_r || out_tready) begin
          // Hand the result to the output register; a zero limit gives black.
          out_iter_nxt = n_r;
          out_gray_nxt = (limit_r == '0) ? '0 : quo_r;
          load_out     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_tready) || load_out;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    n_r        <= n_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    xy_r       <= xy_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_iter_r <= out_iter_nxt;
    out_gray_r <= out_gray_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_gray_r, out_iter_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A delivered count never exceeds the limit.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[LIMIT_W-1:0] <= limit_r))
    else $error("iteration count above limit");

  // The divider starts with a partial remainder below the divisor.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_cnt_r == '0 && limit_r != '0) |-> (rem_r < limit_r))
    else $error("divider remainder out of range");

  // A point that ran to the limit comes out full white.
  a_full_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && limit_r != '0 && out_tdata[LIMIT_W-1:0] == limit_r)
      |-> (out_tdata[LIMIT_W+COLOR_W-1:LIMIT_W] == COLOR_FULL))
    else $error("gray level wrong at limit");
`endif

endmodule
